// ----- hw/rtl/band_weighted_moments_magnitude_macros.svh -----
// ----------------------------------------------------------------------------
// Band weighted moments: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BAND_WEIGHTED_MOMENTS_MAGNITUDE_MACROS_SVH
`define BAND_WEIGHTED_MOMENTS_MAGNITUDE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bwm_pkg.sv -----
// ----------------------------------------------------------------------------
// bwm_pkg
// Sizes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bwm_pkg;

  // accumulator width, 48 to 64
  localparam int ACC_WIDTH = 64;
  // restoring divider steps: dividend bits plus 24 fraction bits
  localparam int DIV_ITER  = ACC_WIDTH + 24;
  localparam int CNT_W     = $clog2(DIV_ITER);
  localparam int SH_W      = $clog2(ACC_WIDTH);
  localparam int MOM_LAST  = 5;
  localparam int RATIO_LAST = 4;
  localparam int LOG_ITER  = 24;
  localparam int POST_LAST = 3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [2:0]       idx_t;

  typedef struct packed {
    logic       load_in;
    logic       calc_sq;
    logic       mom_step;
    idx_t       mom_idx;
    logic       div_init;
    logic       div_step;
    logic       div_last;
    idx_t       div_idx;
    logic       norm_init;
    logic       norm_step;
    logic       log_init;
    logic       log_step;
    logic       mag_calc;
    logic       post_step;
    logic [1:0] post_idx;
    logic       out_load;
  } bwm_cmd_t;

  typedef struct packed {
    logic flux_ok;
    logic last;
    logic out_busy;
    logic norm_done;
  } bwm_sts_t;

endpackage

// ----- hw/rtl/bwm_in_if.sv -----
// ----------------------------------------------------------------------------
// bwm_in_if
// Sample channel: valid/ready handshake with one passband sample per item.
// ----------------------------------------------------------------------------
interface bwm_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        weight;
  logic signed [23:0] ext_k;
  logic signed [23:0] ext_s;
  logic [31:0]        flux;
  logic               is_hbeta;
  logic               last;

  modport source (output valid, weight, ext_k, ext_s, flux, is_hbeta, last,
                  input ready);
  modport sink   (input valid, weight, ext_k, ext_s, flux, is_hbeta, last,
                  output ready);
endinterface

// ----- hw/rtl/bwm_out_if.sv -----
// ----------------------------------------------------------------------------
// bwm_out_if
// Result channel: valid/ready handshake with one band result per item.
// ----------------------------------------------------------------------------
interface bwm_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] intensity;
  logic signed [31:0] mean_k;
  logic signed [31:0] mean_s;
  logic [30:0]        var_k;
  logic signed [31:0] cov_ks;
  logic [30:0]        var_s;
  logic signed [31:0] magnitude;
  logic               valid_res;

  modport source (output valid, intensity, mean_k, mean_s, var_k, cov_ks, var_s,
                  magnitude, valid_res, input ready);
  modport sink   (input valid, intensity, mean_k, mean_s, var_k, cov_ks, var_s,
                  magnitude, valid_res, output ready);
endinterface

// ----- hw/rtl/band_weighted_moments_magnitude.sv -----
// ----------------------------------------------------------------------------
// band_weighted_moments_magnitude
// Band weighted extinction moments and synthetic magnitude, top level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one passband sample per item (weight, ext_k, ext_s, flux,
//   is_hbeta, last). Six saturating sums build up over the band. The item
//   with last set produces one result item on out_ch; other items give none.
//   cfg_we/cfg_wdata write the AB zero point; the user must write it only
//   while the block is idle, and the block itself does not enforce this.
// Sequence:
//   Each accepted sample runs capture, squares and six steps through the
//   shared moment multiplier and accumulator adder before ready returns.
//   A last sample then runs five bit-serial divides, the normalize shift,
//   24 mantissa squarings and the scaling steps.
// Reset (synchronous rst_n low): sums, zero point and result valid clear.
// Stall: the result sits in an output register until out_ch.ready; further
//   samples of the next band are taken meanwhile, and only its last sample
//   waits for the output register to empty.
// ----------------------------------------------------------------------------
module band_weighted_moments_magnitude (
  input  logic        clk,
  input  logic        rst_n,
  bwm_in_if.sink      in_ch,
  bwm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  bwm_pkg::bwm_cmd_t cmd;
  bwm_pkg::bwm_sts_t sts;

  // sequencer
  bwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and result register
  bwm_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_weight     (in_ch.weight),
    .in_ext_k      (in_ch.ext_k),
    .in_ext_s      (in_ch.ext_s),
    .in_flux       (in_ch.flux),
    .in_is_hbeta   (in_ch.is_hbeta),
    .in_last       (in_ch.last),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_intensity (out_ch.intensity),
    .out_mean_k    (out_ch.mean_k),
    .out_mean_s    (out_ch.mean_s),
    .out_var_k     (out_ch.var_k),
    .out_cov_ks    (out_ch.cov_ks),
    .out_var_s     (out_ch.var_s),
    .out_magnitude (out_ch.magnitude),
    .out_valid_res (out_ch.valid_res)
  );

endmodule

// ----- hw/rtl/bwm_datapath.sv -----
// ----------------------------------------------------------------------------
// bwm_datapath
// Accumulators, shared divider, log2 unit, moment post-processing, result reg.
// ----------------------------------------------------------------------------
module bwm_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  bwm_pkg::bwm_cmd_t  cmd,
  output bwm_pkg::bwm_sts_t  sts,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic [31:0]        in_weight,
  input  logic signed [23:0] in_ext_k,
  input  logic signed [23:0] in_ext_s,
  input  logic [31:0]        in_flux,
  input  logic               in_is_hbeta,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_intensity,
  output logic signed [31:0] out_mean_k,
  output logic signed [31:0] out_mean_s,
  output logic [30:0]        out_var_k,
  output logic signed [31:0] out_cov_ks,
  output logic [30:0]        out_var_s,
  output logic signed [31:0] out_magnitude,
  output logic               out_valid_res
);

  localparam int A = bwm_pkg::ACC_WIDTH;
  localparam logic signed [65:0] SAT_MAX = (66'sd1 <<< (A - 1)) - 66'sd1;
  localparam logic signed [65:0] SAT_MIN = -(66'sd1 <<< (A - 1));
  localparam logic [41:0] RATIO_CAP = 42'd1 << 40;
  // 2.5*log10(2) in Q0.32
  localparam logic [31:0] LOG_COEF = 32'd3232284966;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -44'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

  function automatic logic [30:0] clamp31(input logic signed [43:0] v);
    if (v < 44'sd0)                clamp31 = 31'd0;
    else if (v > 44'sd2147483647)  clamp31 = 31'h7fffffff;
    else                           clamp31 = v[30:0];
  endfunction

  // captured sample
  logic [31:0]        w_r, f_r;
  logic signed [23:0] k_r, s_r;
  logic               hb_r, last_r;
  logic signed [31:0] zp_r;

  // per-sample products
  logic [47:0]        p_r;
  logic signed [31:0] kk_r, ks_r, ss_r;
  logic signed [56:0] ph_r, pl_r;
  logic signed [A-1:0] sum_r [6];

  // divider
  logic [A-1:0]        num_r, rem_r;
  logic                neg_r;
  logic [40:0]         q_r;
  logic signed [41:0]  e_r [5];

  // log2 and magnitude
  logic [A-1:0]        xs_r;
  logic [bwm_pkg::SH_W-1:0] sh_r;
  logic [30:0]         m_r;
  logic [23:0]         frac_r;
  logic [62:0]         prod_r;
  logic                lgneg_r;

  // post-processing
  logic signed [63:0]  mp_r;
  logic signed [31:0]  mag_r, cv_r;
  logic [30:0]         vk_r, vs_r;
  logic                out_valid_r;

  // ---- square terms and weighted flux
  logic [63:0]        wf;
  logic signed [47:0] kk_full, ks_full, ss_full;
  assign wf      = 64'(w_r) * 64'(f_r);
  assign kk_full = 48'(k_r) * 48'(k_r);
  assign ks_full = 48'(k_r) * 48'(s_r);
  assign ss_full = 48'(s_r) * 48'(s_r);

  // ---- moment step: multiply for moment idx, add term of previous moment
  logic signed [31:0] bsel;
  logic signed [24:0] hi_s, lo_s;
  logic signed [40:0] pl_sh;
  logic signed [65:0] term, addend, acc_sum, acc_sat;

  always_comb begin
    case (cmd.mom_idx)
      3'd0:    bsel = 32'(k_r);
      3'd1:    bsel = 32'(s_r);
      3'd2:    bsel = kk_r;
      3'd3:    bsel = ks_r;
      3'd4:    bsel = ss_r;
      default: bsel = 32'sd0;
    endcase
  end

  assign hi_s   = $signed({1'b0, p_r[47:24]});
  assign lo_s   = $signed({1'b0, p_r[23:0]});
  assign pl_sh  = $signed(pl_r[56:16]);
  assign term   = (66'(ph_r) <<< 8) + 66'(pl_sh);
  assign addend = (cmd.mom_idx == 3'd0) ? 66'($signed({1'b0, p_r})) : term;
  assign acc_sum = 66'(sum_r[cmd.mom_idx]) + addend;

  always_comb begin
    if (acc_sum > SAT_MAX)      acc_sat = SAT_MAX;
    else if (acc_sum < SAT_MIN) acc_sat = SAT_MIN;
    else                        acc_sat = acc_sum;
  end

  // ---- divider step, one quotient bit per cycle, capped at 2^40
  logic [A-1:0]        den, div_src, rsh, rem_nxt;
  logic                ge;
  logic [41:0]         qsh;
  logic [40:0]         q_nxt;
  logic signed [41:0]  qv, e_nxt;

  assign den     = sum_r[0];
  assign div_src = sum_r[cmd.div_idx + 3'd1];
  assign rsh     = {rem_r[A-2:0], num_r[A-1]};
  assign ge      = (rsh >= den);
  assign rem_nxt = ge ? (rsh - den) : rsh;
  assign qsh     = {q_r, ge};
  assign q_nxt   = (qsh > RATIO_CAP) ? RATIO_CAP[40:0] : qsh[40:0];
  assign qv      = $signed({1'b0, q_nxt});
  assign e_nxt   = neg_r ? -qv : qv;

  // ---- log2 squaring step and magnitude scale
  logic [61:0]        msq;
  logic [31:0]        mt;
  logic signed [7:0]  lexp;
  logic signed [31:0] lg;
  logic [31:0]        labs;

  assign msq  = 62'(m_r) * 62'(m_r);
  assign mt   = msq[61:30];
  assign lexp = 8'(A - 17) - 8'(sh_r);
  assign lg   = $signed({lexp, frac_r});
  assign labs = lg[31] ? 32'(-lg) : lg;

  // ---- final fields
  logic signed [31:0] mk, ms, ma, mb;
  logic signed [39:0] mp_sh;
  logic [63:0]        rnd;
  logic signed [33:0] lm34, mag_w;

  assign mk    = sat32(44'(e_r[0]));
  assign ms    = sat32(44'(e_r[1]));
  assign mp_sh = $signed(mp_r[63:24]);
  assign rnd   = 64'(prod_r) + 64'h8000_0000;
  assign lm34  = $signed({2'b00, rnd[63:32]});
  assign mag_w = (lgneg_r ? lm34 : -lm34) + (hb_r ? 34'sd0 : 34'(zp_r));

  always_comb begin
    case (cmd.post_idx)
      2'd1:    begin ma = ms; mb = ms; end
      2'd2:    begin ma = mk; mb = ms; end
      default: begin ma = mk; mb = mk; end
    endcase
  end

  // ---- control registers: sums, config, output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) sum_r[i] <= '0;
      zp_r        <= 32'sd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) zp_r <= $signed(cfg_wdata);
      if (cmd.mom_step) sum_r[cmd.mom_idx] <= A'(acc_sat);
      if (cmd.out_load) begin
        for (int i = 0; i < 6; i++) sum_r[i] <= '0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      w_r    <= in_weight;
      f_r    <= in_flux;
      k_r    <= in_ext_k;
      s_r    <= in_ext_s;
      hb_r   <= in_is_hbeta;
      last_r <= in_last;
    end
    if (cmd.calc_sq) begin
      p_r  <= wf[63:16];
      kk_r <= kk_full[47:16];
      ks_r <= ks_full[47:16];
      ss_r <= ss_full[47:16];
    end
    if (cmd.mom_step) begin
      ph_r <= 57'(hi_s) * 57'(bsel);
      pl_r <= 57'(lo_s) * 57'(bsel);
    end
    // divider
    if (cmd.div_init) begin
      neg_r <= div_src[A-1];
      num_r <= div_src[A-1] ? A'(-div_src) : div_src;
      rem_r <= '0;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
    if (cmd.div_last) e_r[cmd.div_idx] <= e_nxt;
    // normalize intensity, then square the mantissa
    if (cmd.norm_init) begin
      xs_r <= den;
      sh_r <= '0;
    end else if (cmd.norm_step) begin
      xs_r <= xs_r << 1;
      sh_r <= sh_r + 1'b1;
    end
    if (cmd.log_init) begin
      m_r    <= xs_r[A-1 -: 31];
      frac_r <= '0;
    end else if (cmd.log_step) begin
      if (mt[31]) begin
        m_r    <= mt[31:1];
        frac_r <= {frac_r[22:0], 1'b1};
      end else begin
        m_r    <= mt[30:0];
        frac_r <= {frac_r[22:0], 1'b0};
      end
    end
    if (cmd.mag_calc) begin
      prod_r  <= 63'(labs[30:0]) * 63'(LOG_COEF);
      lgneg_r <= lg[31];
    end
    // post: multiply mean products, finish field of previous step
    if (cmd.post_step) begin
      mp_r <= 64'(ma) * 64'(mb);
      case (cmd.post_idx)
        2'd0:    mag_r <= sat32(44'(mag_w));
        2'd1:    vk_r  <= clamp31(44'(e_r[2]) - 44'(mp_sh));
        2'd2:    vs_r  <= clamp31(44'(e_r[4]) - 44'(mp_sh));
        default: cv_r  <= sat32(44'(e_r[3]) - 44'(mp_sh));
      endcase
    end
    // result register
    if (cmd.out_load) begin
      out_intensity <= 64'(sum_r[0]);
      out_valid_res <= sts.flux_ok;
      if (sts.flux_ok) begin
        out_mean_k    <= mk;
        out_mean_s    <= ms;
        out_var_k     <= vk_r;
        out_var_s     <= vs_r;
        out_cov_ks    <= cv_r;
        out_magnitude <= mag_r;
      end else begin
        out_mean_k    <= 32'sd0;
        out_mean_s    <= 32'sd0;
        out_var_k     <= 31'd0;
        out_var_s     <= 31'd0;
        out_cov_ks    <= 32'sd0;
        out_magnitude <= 32'sd0;
      end
    end
  end

  // ---- status
  assign sts.flux_ok   = (sum_r[0] > '0) && (66'(sum_r[0]) < SAT_MAX);
  assign sts.last      = last_r;
  assign sts.out_busy  = out_valid_r;
  assign sts.norm_done = xs_r[A-1];
  assign out_valid     = out_valid_r;

endmodule

// ----- hw/rtl/bwm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bwm_ctrl
// Sequencer: sample accumulation, per-band divides, log2 and result handoff.
// ----------------------------------------------------------------------------
`include "band_weighted_moments_magnitude_macros.svh"

module bwm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bwm_pkg::bwm_sts_t sts,
  output bwm_pkg::bwm_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SQ    = 11'b000_0000_0010,
    S_MOM   = 11'b000_0000_0100,
    S_DIVI  = 11'b000_0000_1000,
    S_DIV   = 11'b000_0001_0000,
    S_NORMI = 11'b000_0010_0000,
    S_NORM  = 11'b000_0100_0000,
    S_LOG   = 11'b000_1000_0000,
    S_MAG   = 11'b001_0000_0000,
    S_POST  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  localparam bwm_pkg::cnt_t MOM_END  = bwm_pkg::cnt_t'(bwm_pkg::MOM_LAST);
  localparam bwm_pkg::cnt_t DIV_END  = bwm_pkg::cnt_t'(bwm_pkg::DIV_ITER - 1);
  localparam bwm_pkg::cnt_t LOG_END  = bwm_pkg::cnt_t'(bwm_pkg::LOG_ITER - 1);
  localparam bwm_pkg::cnt_t POST_END = bwm_pkg::cnt_t'(bwm_pkg::POST_LAST);
  localparam bwm_pkg::idx_t RAT_END  = bwm_pkg::idx_t'(bwm_pkg::RATIO_LAST);

  state_t        state_r, state_nxt;
  bwm_pkg::cnt_t cnt_r, cnt_nxt;
  bwm_pkg::idx_t idx_r, idx_nxt;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mom_idx  = cnt_r[2:0];
    cmd.div_idx  = idx_r;
    cmd.post_idx = cnt_r[1:0];
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        cmd.calc_sq = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_MOM;
      end
      S_MOM: begin
        cmd.mom_step = 1'b1;
        if (cnt_r == MOM_END) begin
          cnt_nxt = '0;
          idx_nxt = '0;
          if (!sts.last)        state_nxt = S_IDLE;
          else if (sts.flux_ok) state_nxt = S_DIVI;
          else                  state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_END) begin
          cmd.div_last = 1'b1;
          cnt_nxt      = '0;
          if (idx_r == RAT_END) begin
            state_nxt = S_NORMI;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_DIVI;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_NORMI: begin
        cmd.norm_init = 1'b1;
        state_nxt     = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_done) begin
          cmd.log_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_LOG;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        if (cnt_r == LOG_END) begin
          cnt_nxt   = '0;
          state_nxt = S_MAG;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MAG: begin
        cmd.mag_calc = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_POST;
      end
      S_POST: begin
        cmd.post_step = 1'b1;
        if (cnt_r == POST_END) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // checks
  `BWM_ASSERT_SAME(a_load_free, cmd.out_load, !sts.out_busy, "result loaded over pending item")
  `BWM_ASSERT_NEXT(a_accept_sq, in_valid && in_ready, state_r == S_SQ, "accept did not start item")
  `BWM_ASSERT_SAME(a_div_ok, state_r == S_DIVI, sts.flux_ok, "divide started on invalid band")

endmodule

// ----- tb/band_weighted_moments_magnitude_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_weighted_moments_magnitude_test
// Drives passband samples band by band at random pace, predicts each band
// result (moments, variances, covariance, magnitude, valid flag) and checks
// every result item against the oldest prediction.
// ----------------------------------------------------------------------------
module band_weighted_moments_magnitude_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 700;

  typedef struct {
    logic [31:0]        weight;
    logic signed [23:0] ext_k;
    logic signed [23:0] ext_s;
    logic [31:0]        flux;
    logic               is_hbeta;
    logic               last;
  } sample_t;

  typedef struct {
    logic signed [63:0] intensity;
    logic signed [31:0] mean_k;
    logic signed [31:0] mean_s;
    logic [30:0]        var_k;
    logic signed [31:0] cov_ks;
    logic [30:0]        var_s;
    logic signed [31:0] magnitude;
    logic               valid_res;
  } band_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  bwm_in_if  in_ch ();
  bwm_out_if out_ch ();

  band_weighted_moments_magnitude dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sample_t      pending_samples[$];
  band_result_t expected_bands[$];
  int           errors = 0;
  int           max_gap = 5;
  int           max_stall = 5;
  bit           in_taken = 1'b0;
  int           idle_cycles = 0;

  // predictor state
  longint zero_point = 0;
  longint acc_flux, acc_k, acc_s, acc_kk, acc_ks, acc_ss;

  localparam longint ACC_HI = 64'sh7fff_ffff_ffff_ffff;
  localparam longint ACC_LO = -64'sh7fff_ffff_ffff_ffff - 1;

  function automatic longint sat_acc(longint a, logic signed [127:0] t);
    logic signed [127:0] sum;
    sum = a;
    sum = sum + t;
    if (sum > ACC_HI) return ACC_HI;
    if (sum < ACC_LO) return ACC_LO;
    return longint'(sum);
  endfunction

  // floor(p*b/2^16)
  function automatic logic signed [127:0] scale_q16(longint unsigned p, longint b);
    logic signed [127:0] pw, bw;
    pw = {64'd0, p};
    bw = b;
    return (pw * bw) >>> 16;
  endfunction

  // sum*2^24/den, truncated toward zero, magnitude capped at 2^40
  function automatic longint ratio_q24(longint num, longint unsigned den);
    logic signed [127:0] n, q;
    bit neg;
    neg = num < 0;
    n = num;
    if (neg) n = -n;
    q = (n <<< 24) / $signed({64'd0, den});
    if (q > (128'sd1 <<< 40)) q = 128'sd1 <<< 40;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // log2 in Q8.24 by repeated mantissa squaring
  function automatic longint log2_q24(longint unsigned x);
    int n;
    logic [63:0] m;
    longint frac;
    n = 63;
    frac = 0;
    while (n > 0 && !x[n]) n--;
    m = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(n) - 16) * (64'sd1 <<< 24) + frac;
  endfunction

  // fold one sample into the band sums; on last, form the band result
  task automatic absorb_sample(input sample_t smp, output bit done,
                               output band_result_t r);
    longint unsigned p, den, prod;
    longint k, s, mk, ms, vk, vs, cv, mag, lg;
    p = (longint'(smp.weight) * longint'(smp.flux)) >> 16;
    k = smp.ext_k;
    s = smp.ext_s;
    acc_flux = sat_acc(acc_flux, {64'd0, p});
    acc_k  = sat_acc(acc_k, scale_q16(p, k));
    acc_s  = sat_acc(acc_s, scale_q16(p, s));
    acc_kk = sat_acc(acc_kk, scale_q16(p, (k * k) >>> 16));
    acc_ks = sat_acc(acc_ks, scale_q16(p, (k * s) >>> 16));
    acc_ss = sat_acc(acc_ss, scale_q16(p, (s * s) >>> 16));
    done = smp.last;
    if (!done) return;
    mk = 0; ms = 0; vk = 0; vs = 0; cv = 0; mag = 0;
    r.valid_res = acc_flux > 0 && acc_flux < ACC_HI;
    if (r.valid_res) begin
      den = acc_flux;
      mk = sat32(ratio_q24(acc_k, den));
      ms = sat32(ratio_q24(acc_s, den));
      vk = ratio_q24(acc_kk, den) - ((mk * mk) >>> 24);
      vs = ratio_q24(acc_ss, den) - ((ms * ms) >>> 24);
      vk = vk < 0 ? 0 : (vk > 64'sd2147483647 ? 64'sd2147483647 : vk);
      vs = vs < 0 ? 0 : (vs > 64'sd2147483647 ? 64'sd2147483647 : vs);
      cv = sat32(ratio_q24(acc_ks, den) - ((mk * ms) >>> 24));
      lg = log2_q24(den);
      prod = longint'(lg < 0 ? -lg : lg) * 64'd3232284966;
      mag = longint'((prod + (64'd1 << 31)) >> 32);
      if (lg >= 0) mag = -mag;
      if (!smp.is_hbeta) mag = mag + zero_point;
      mag = sat32(mag);
    end
    r.intensity = acc_flux;
    r.mean_k    = mk[31:0];
    r.mean_s    = ms[31:0];
    r.var_k     = vk[30:0];
    r.cov_ks    = cv[31:0];
    r.var_s     = vs[30:0];
    r.magnitude = mag[31:0];
    acc_flux = 0; acc_k = 0; acc_s = 0; acc_kk = 0; acc_ks = 0; acc_ss = 0;
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // input driver
  always @(negedge clk) begin
    sample_t smp;
    int gap_left;
    logic nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else if (!(in_ch.valid && !in_taken)) begin
      nv = 1'b0;
      if (in_taken) gap_left = $urandom_range(0, max_gap);
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_samples.size() > 0) begin
        smp = pending_samples.pop_front();
        in_ch.weight   <= smp.weight;
        in_ch.ext_k    <= smp.ext_k;
        in_ch.ext_s    <= smp.ext_s;
        in_ch.flux     <= smp.flux;
        in_ch.is_hbeta <= smp.is_hbeta;
        in_ch.last     <= smp.last;
        nv = 1'b1;
      end
      in_ch.valid <= nv;
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    int stall_left;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall_left = $urandom_range(0, max_stall);
      out_ch.ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= (stall_left == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted samples, check accepted results
  always @(posedge clk) begin
    sample_t smp;
    band_result_t r, want;
    bit done;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        smp.weight = in_ch.weight;   smp.ext_k = in_ch.ext_k;
        smp.ext_s = in_ch.ext_s;     smp.flux = in_ch.flux;
        smp.is_hbeta = in_ch.is_hbeta; smp.last = in_ch.last;
        absorb_sample(smp, done, r);
        if (done) expected_bands.insert(expected_bands.size(), r);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bands.size() == 0) begin
          report_mismatch("unexpected result", out_ch.intensity, '0);
        end else begin
          want = expected_bands.pop_front();
          if (out_ch.intensity !== want.intensity)
            report_mismatch("intensity", out_ch.intensity, want.intensity);
          if (out_ch.mean_k !== want.mean_k)
            report_mismatch("mean_k", out_ch.mean_k, want.mean_k);
          if (out_ch.mean_s !== want.mean_s)
            report_mismatch("mean_s", out_ch.mean_s, want.mean_s);
          if (out_ch.var_k !== want.var_k)
            report_mismatch("var_k", out_ch.var_k, want.var_k);
          if (out_ch.cov_ks !== want.cov_ks)
            report_mismatch("cov_ks", out_ch.cov_ks, want.cov_ks);
          if (out_ch.var_s !== want.var_s)
            report_mismatch("var_s", out_ch.var_s, want.var_s);
          if (out_ch.magnitude !== want.magnitude)
            report_mismatch("magnitude", out_ch.magnitude, want.magnitude);
          if (out_ch.valid_res !== want.valid_res)
            report_mismatch("valid_res", out_ch.valid_res, want.valid_res);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("band_weighted_moments_magnitude regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_u32();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(0, 255);
      3: return $urandom_range(32'h8000, 32'h4_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] pick_s24();
    case ($urandom_range(0, 6))
      0: return 24'h7f_ffff;
      1: return 24'h80_0000;
      2: return 24'd0;
      3: return 24'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_sample(input logic [31:0] w, input logic [23:0] k,
                            input logic [23:0] s, input logic [31:0] f,
                            input logic hb, input logic lst);
    sample_t smp;
    smp.weight = w; smp.ext_k = k; smp.ext_s = s; smp.flux = f;
    smp.is_hbeta = hb; smp.last = lst;
    pending_samples.insert(pending_samples.size(), smp);
  endtask

  // wait until the block is idle, then write the zero point
  task automatic write_zero_point(input logic [31:0] zp);
    wait (pending_samples.size() == 0 && !in_ch.valid && expected_bands.size() == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= zp;
    zero_point = $signed(zp);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random bands: mostly well formed, some zero flux
  task automatic add_random_bands(input int n_items);
    int len, made;
    logic [31:0] w, f;
    made = 0;
    while (made < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        w = pick_u32();
        f = pick_u32();
        if ($urandom_range(0, 15) == 0) f = 32'd0;
        add_sample(w, pick_s24(), pick_s24(), f, $urandom_range(0, 1), i == len - 1);
      end
      made += len;
    end
  endtask

  initial begin
    acc_flux = 0; acc_k = 0; acc_s = 0; acc_kk = 0; acc_ks = 0; acc_ss = 0;
    in_ch.valid = 1'b0;
    in_ch.weight = '0; in_ch.ext_k = '0; in_ch.ext_s = '0; in_ch.flux = '0;
    in_ch.is_hbeta = 1'b0; in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, invalid bands, tiny intensity, hbeta
    write_zero_point(32'h1234_5678);
    add_sample(32'hffff_ffff, 24'h7f_ffff, 24'h80_0000, 32'hffff_ffff, 1'b0, 1'b1);
    add_sample(32'hffff_ffff, 24'h80_0000, 24'h7f_ffff, 32'hffff_ffff, 1'b1, 1'b1);
    add_sample(32'd0, 24'h7f_ffff, 24'h7f_ffff, 32'hffff_ffff, 1'b0, 1'b1);
    add_sample(32'd1, 24'h01_0000, 24'h01_0000, 32'd1, 1'b0, 1'b1);
    add_sample(32'd1, 24'h01_0000, 24'hff_0000, 32'h1_0000, 1'b0, 1'b1);
    add_sample(32'h1_0000, 24'h80_0000, 24'h80_0000, 32'h1_0000, 1'b1, 1'b1);
    add_sample(32'h1_0000, 24'h7f_ffff, 24'h00_0000, 32'h1_0000, 1'b1, 1'b0);
    add_sample(32'h1_0000, 24'h80_0000, 24'h00_0000, 32'h1_0000, 1'b0, 1'b1);
    add_sample(32'hffff_ffff, 24'h7f_ffff, 24'h7f_ffff, 32'd1, 1'b0, 1'b0);
    add_sample(32'd1, 24'h80_0000, 24'h80_0000, 32'hffff_ffff, 1'b1, 1'b0);
    add_sample(32'h2_0000, 24'h00_8000, 24'hff_8000, 32'h3_0000, 1'b0, 1'b1);
    add_sample(32'h0_8000, 24'h00_0000, 24'h00_0000, 32'h0_8000, 1'b0, 1'b1);
    add_sample(32'h0, 24'h0, 24'h0, 32'h0, 1'b1, 1'b1);
    write_zero_point(32'h7fff_ffff);
    add_sample(32'd1, 24'h0, 24'h0, 32'd1, 1'b0, 1'b0);
    add_sample(32'd1, 24'h0, 24'h0, 32'h1_0000, 1'b0, 1'b1);
    add_sample(32'hffff_ffff, 24'h0, 24'h0, 32'hffff_ffff, 1'b0, 1'b1);
    write_zero_point(32'h8000_0000);
    add_sample(32'hffff_ffff, 24'h0, 24'h0, 32'hffff_ffff, 1'b0, 1'b1);
    add_sample(32'd1, 24'h0, 24'h0, 32'h1_0000, 1'b0, 1'b1);
    add_sample(32'd1, 24'h0, 24'h0, 32'h1_0000, 1'b1, 1'b1);

    // random phases under several zero points, with and without idling
    add_random_bands(450);
    write_zero_point($urandom);
    max_gap = 0; max_stall = 0;
    add_random_bands(450);
    write_zero_point(32'd0);
    max_gap = 5; max_stall = 5;
    add_random_bands(500);
    write_zero_point($urandom);
    max_stall = 0;
    add_random_bands(500);

    // negative zero point, back to back samples, stalled results
    write_zero_point(32'hfe00_0000);
    max_gap = 0; max_stall = 5;
    add_random_bands(20);

    wait (pending_samples.size() == 0 && !in_ch.valid && expected_bands.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("band_weighted_moments_magnitude regression: pass");
    else
      $display("band_weighted_moments_magnitude regression: fail");
    $finish;
  end

endmodule
